FILE: rtl/mahf_pkg.sv
// ----------------------------------------------------------------------------
// MAC address hash filter package
// Transaction types and the CRC-32 hash constants of the 64-bin filter.
// ----------------------------------------------------------------------------
package mahf_pkg;

    localparam int AddrBits   = 48;
    localparam int AddrBytes  = AddrBits / 8;
    localparam int BinBits    = 6;
    localparam int NumBins    = 1 << BinBits;
    localparam int CrcBits    = 32;
    localparam logic [CrcBits-1:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [CrcBits-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam int GroupBit   = AddrBits - 8;

    typedef logic [BinBits-1:0] bin_t;
    typedef logic [NumBins-1:0] bins_t;

    typedef struct packed {
        logic [AddrBits-1:0] mac_addr;
        logic                entry_valid;
        logic                first_entry;
    } cmd_t;

    typedef struct packed {
        bin_t  bin_index;
        logic  is_multicast;
        bins_t unicast_table;
        bins_t multicast_table;
    } rsp_t;

    typedef struct packed {
        logic apply;
        logic clear;
        logic set;
        logic mcast;
        bin_t bin;
    } tbl_upd_t;

    // Reflected CRC-32 over the address bytes, first byte first, no final
    // inversion. Used only to build the constants below.
    function automatic logic [CrcBits-1:0] addr_crc(input logic [AddrBits-1:0] addr,
                                                    input logic [CrcBits-1:0] preset);
        logic [CrcBits-1:0] crc;
        crc = preset;
        for (int i = 0; i < AddrBytes; i++) begin
            crc[7:0] = crc[7:0] ^ addr[AddrBits-1-8*i -: 8];
            for (int b = 0; b < 8; b++) begin
                if (crc[0]) begin
                    crc = (crc >> 1) ^ CRC_POLY;
                end
                else begin
                    crc = crc >> 1;
                end
            end
        end
        return crc;
    endfunction

    // The CRC is linear in the address bits: each address bit flips a fixed
    // set of bin bits on top of the contribution of the preset.
    function automatic logic [AddrBits-1:0][BinBits-1:0] hash_columns();
        logic [AddrBits-1:0][BinBits-1:0] cols;
        logic [CrcBits-1:0]               crc;
        for (int i = 0; i < AddrBits; i++) begin
            crc     = addr_crc(AddrBits'(1) << i, '0);
            cols[i] = crc[CrcBits-1 -: BinBits];
        end
        return cols;
    endfunction

    localparam logic [AddrBits-1:0][BinBits-1:0] HASH_COLS = hash_columns();
    localparam bin_t HASH_PRESET =
        bin_t'(addr_crc('0, CRC_PRESET) >> (CrcBits - BinBits));

endpackage

FILE: rtl/mahf_hash.sv
// ----------------------------------------------------------------------------
// MAC address hash
// Computes the 6-bit bin, CRC-32 bits 31..26, of a 48-bit address as an XOR
// tree of the address bits.
// ----------------------------------------------------------------------------
module mahf_hash
    import mahf_pkg::*;
(
    input  logic [AddrBits-1:0] mac_addr,
    output bin_t                bin
);

    always_comb
    begin
        bin = HASH_PRESET;
        for (int i = 0; i < AddrBits; i++) begin
            if (mac_addr[i]) begin
                bin = bin ^ HASH_COLS[i];
            end
        end
    end

endmodule

FILE: rtl/mahf_tables.sv
// ----------------------------------------------------------------------------
// MAC address hash tables
// Holds the unicast and multicast 64-bin tables and applies one update per
// transaction: an optional clear, then the optional setting of one bin.
// ----------------------------------------------------------------------------
module mahf_tables
    import mahf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_upd_t upd,
    output bins_t    unicast_table,
    output bins_t    multicast_table
);

    bins_t uni_reg;
    bins_t uni_next;
    bins_t mc_reg;
    bins_t mc_next;
    bins_t onehot;

    always_comb
    begin
        onehot   = bins_t'(1) << upd.bin;
        uni_next = upd.clear ? '0 : uni_reg;
        mc_next  = upd.clear ? '0 : mc_reg;
        if (upd.set) begin
            if (upd.mcast) begin
                mc_next = mc_next | onehot;
            end
            else begin
                uni_next = uni_next | onehot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            uni_reg <= '0;
            mc_reg  <= '0;
        end
        else if (upd.apply) begin
            uni_reg <= uni_next;
            mc_reg  <= mc_next;
        end
    end

    assign unicast_table   = uni_reg;
    assign multicast_table = mc_reg;

endmodule

FILE: rtl/mac_address_hash_filter.sv
// ----------------------------------------------------------------------------
// MAC address hash filter
// Builds the 64-bin unicast and multicast hash tables of a receive filter.
//
// The cmd channel carries one filter entry per transaction: a 48-bit address,
// first transmitted byte in bits 47..40, a valid flag, and a flag that clears
// both tables before the entry is applied. The rsp channel returns one
// transaction per entry with the hash bin, the class and both tables as they
// stand after the entry. Both channels use valid and stall.
// A transaction is registered at the input, hashed by an XOR tree and
// applied to the tables on its way into the result register, which it
// enters once that register is free; one entry is accepted every cycle
// while the receiver does not stall.
// When the receiver stalls, the result holds and the input stage takes one
// more entry before cmd_stall rises; cmd_stall depends on rsp_stall.
// Reset clears both tables and empties both stages.
// ----------------------------------------------------------------------------
module mac_address_hash_filter
    import mahf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    cmd_t     s1_reg;
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    bin_t     bin_reg;
    bin_t     bin_next;
    logic     mcast_reg;
    logic     mcast_next;
    logic     accept;
    logic     advance;
    bin_t     hash_bin;
    tbl_upd_t upd;
    bins_t    unicast_table;
    bins_t    multicast_table;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);

    mahf_hash u_hash (
        .mac_addr (s1_reg.mac_addr),
        .bin      (hash_bin)
    );

    always_comb
    begin
        upd.apply  = advance;
        upd.clear  = s1_reg.first_entry;
        upd.set    = s1_reg.entry_valid;
        upd.mcast  = s1_reg.mac_addr[GroupBit];
        upd.bin    = hash_bin;
        bin_next   = s1_reg.entry_valid ? hash_bin : '0;
        mcast_next = s1_reg.entry_valid && s1_reg.mac_addr[GroupBit];
    end

    mahf_tables u_tables (
        .clk             (clk),
        .rst_n           (rst_n),
        .upd             (upd),
        .unicast_table   (unicast_table),
        .multicast_table (multicast_table)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_reg <= cmd;
        end
        if (advance) begin
            bin_reg   <= bin_next;
            mcast_reg <= mcast_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        rsp.bin_index       = bin_reg;
        rsp.is_multicast    = mcast_reg;
        rsp.unicast_table   = unicast_table;
        rsp.multicast_table = multicast_table;
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg && rsp_valid_reg && rsp_stall)
        else $error("Input stalled while a stage was free.");

    a_clear_without_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reg.first_entry && !s1_reg.entry_valid)
        |=> (unicast_table == '0) && (multicast_table == '0))
        else $error("Tables not cleared by an invalid first entry.");

    a_bin_set: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reg.entry_valid)
        |=> (mcast_reg ? multicast_table[bin_reg] : unicast_table[bin_reg]))
        else $error("Hash bin not set in the selected table.");

    a_tables_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall)
        |=> $stable(unicast_table) && $stable(multicast_table) && $stable(bin_reg))
        else $error("Result changed while stalled.");

endmodule

FILE: tb/sv/mahf_table_checker.sv
// ----------------------------------------------------------------------------
// MAC address hash filter table checker
// Watches both channels of the hash filter. It predicts the bin, the class and
// both 64-bin tables for every accepted entry, and compares each accepted
// result with the oldest prediction. It reports the number of mismatches and
// the number of results still outstanding.
// ----------------------------------------------------------------------------
module mahf_table_checker
    import mahf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    localparam logic [31:0] HashPreset = 32'hFFFF_FFFF;
    localparam logic [31:0] HashPoly   = 32'hEDB8_8320;

    bins_t unicast_bins;
    bins_t multicast_bins;
    rsp_t  table_updates[$];

    // The address goes out first byte first, each byte least significant bit
    // first, so the group bit is the first bit through the CRC.
    function automatic bin_t address_bin(input logic [AddrBits-1:0] addr);
        logic [31:0] crc;
        logic        din;
        crc = HashPreset;
        for (int i = 0; i < AddrBits; i++)
        begin
            din = addr[AddrBits - 8 - 8 * (i / 8) + i % 8];
            if (crc[0] ^ din)
            begin
                crc = (crc >> 1) ^ HashPoly;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc[31:26];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   mismatches;
        if (!rst_n)
        begin
            unicast_bins   = '0;
            multicast_bins = '0;
            table_updates.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            mismatches = 0;
            if (rsp_valid && !rsp_stall)
            begin
                if (table_updates.size() == 0)
                begin
                    $error("result transaction with none expected: bin_index %0d",
                           rsp.bin_index);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = table_updates.pop_front();
                    if (rsp.bin_index !== want.bin_index)
                    begin
                        $error("bin_index: expected %0d, actual %0d",
                               want.bin_index, rsp.bin_index);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.is_multicast !== want.is_multicast)
                    begin
                        $error("is_multicast: expected %0b, actual %0b",
                               want.is_multicast, rsp.is_multicast);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.unicast_table !== want.unicast_table)
                    begin
                        $error("unicast_table: expected %h, actual %h",
                               want.unicast_table, rsp.unicast_table);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.multicast_table !== want.multicast_table)
                    begin
                        $error("multicast_table: expected %h, actual %h",
                               want.multicast_table, rsp.multicast_table);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (cmd.first_entry)
                begin
                    unicast_bins   = '0;
                    multicast_bins = '0;
                end
                want = '0;
                if (cmd.entry_valid)
                begin
                    want.bin_index    = address_bin(cmd.mac_addr);
                    want.is_multicast = cmd.mac_addr[GroupBit];
                    if (want.is_multicast)
                    begin
                        multicast_bins[want.bin_index] = 1'b1;
                    end
                    else
                    begin
                        unicast_bins[want.bin_index] = 1'b1;
                    end
                end
                want.unicast_table   = unicast_bins;
                want.multicast_table = multicast_bins;
                table_updates.push_back(want);
            end
            pending    <= table_updates.size();
            fail_count <= fail_count + mismatches;
        end
    end

endmodule

FILE: tb/sv/tb_mac_address_hash_filter.sv
// ----------------------------------------------------------------------------
// MAC address hash filter testbench
// Drives filter entries into the hash filter: a directed set of extreme and
// special addresses first, then random entries in bursts, while the result
// side stalls on its own pattern with long hold-offs. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_mac_address_hash_filter;
    import mahf_pkg::*;

    localparam int RandomEntries = 1330;
    localparam int IdleLimit     = 2000;
    localparam int LongHold      = 200;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    mac_address_hash_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    mahf_table_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cmd_t filter_entry(input logic [AddrBits-1:0] addr,
                                          input logic entry_valid,
                                          input logic first_entry);
        cmd_t entry;
        entry.mac_addr    = addr;
        entry.entry_valid = entry_valid;
        entry.first_entry = first_entry;
        return entry;
    endfunction

    // Most addresses are fully random; some are IPv4 multicast group
    // addresses and some are forced to be individual addresses.
    function automatic cmd_t random_entry();
        cmd_t        entry;
        logic [63:0] raw;
        int          kind;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        entry.mac_addr = raw[AddrBits-1:0];
        if (kind < 2)
        begin
            entry.mac_addr[47:23] = {24'h01005E, 1'b0};
        end
        else if (kind < 4)
        begin
            entry.mac_addr[GroupBit] = 1'b0;
        end
        entry.entry_valid = ($urandom_range(0, 9) != 0);
        entry.first_entry = ($urandom_range(0, 39) == 0);
        return entry;
    endfunction

    task automatic offer_entry(input cmd_t entry);
        cmd_valid <= 1'b1;
        cmd       <= entry;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int sent;
        int burst;
        int gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_entry(filter_entry(48'h0000_0000_0000, 1'b1, 1'b1));
        offer_entry(filter_entry(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0000_0000_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0100_0000_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'hFEFF_FFFF_FFFF, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0100_5E00_0001, 1'b1, 1'b0));
        offer_entry(filter_entry(48'hA5A5_A5A5_A5A5, 1'b0, 1'b0));
        offer_entry(filter_entry(48'h5A5A_5A5A_5A5A, 1'b0, 1'b1));
        offer_entry(filter_entry(48'h0000_0000_0001, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h8000_0000_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0180_C200_0000, 1'b1, 1'b1));
        offer_entry(filter_entry(48'hFFFF_FFFF_FFFF, 1'b0, 1'b0));
        offer_entry(filter_entry(48'h0180_C200_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h3333_0000_0001, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0000_0001_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0200_0000_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'h0200_0000_0000, 1'b1, 1'b0));
        offer_entry(filter_entry(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1));
        offer_entry(filter_entry(48'h0000_0000_0000, 1'b0, 1'b1));
        offer_entry(filter_entry(48'hFFFF_FFFF_FFFE, 1'b1, 1'b0));

        sent = 0;
        while (sent < RandomEntries)
        begin
            burst = $urandom_range(1, 40);
            for (int n = 0; n < burst && sent < RandomEntries; n++)
            begin
                offer_entry(random_entry());
                sent = sent + 1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        cmd_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // The result side alternates between free flow, light and heavy stalls,
    // with a long hold-off now and then so that the input side backs up.
    initial
    begin
        int mode;
        int span;
        int cycles;
        int next_hold;
        cycles    = 0;
        next_hold = 300;
        @(posedge rst_n);
        forever
        begin
            if (cycles >= next_hold)
            begin
                repeat (LongHold)
                begin
                    @(posedge clk);
                    rsp_stall <= 1'b1;
                end
                cycles    = cycles + LongHold;
                next_hold = next_hold + 2000;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
            cycles = cycles + span;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IdleLimit)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
